@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by implicit_list_heap_allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ilha_pkg.sv @@
`timescale 1ns / 1ps

package ilha_pkg;

   // Heap geometry.
   localparam int HEAP_WORDS = 512;
   localparam int ADDR_W     = $clog2(HEAP_WORDS);
   localparam int LEN_W      = ADDR_W + 1;
   localparam int HDR_W      = ADDR_W + 2;
   localparam int NEXT_W     = HDR_W + 1;

   // Header word written at position zero when the heap is formatted.
   localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(HEAP_WORDS);

   // Command codes.
   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_BADLEN  = 2'd2,
      ST_BADADDR = 2'd3
   } status_type;

   // Access request from the sequencer to the header memory.
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [HDR_W-1:0]  wr_data;
   } mem_req_type;

endpackage

@@ hw/rtl/ilha_mem.sv @@
`timescale 1ns / 1ps

module ilha_mem
   import ilha_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [HDR_W-1:0]  rd_data
);

   logic [HDR_W-1:0] store_ff [HEAP_WORDS];
   logic [HDR_W-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ilha_ctrl.sv @@
`timescale 1ns / 1ps

module ilha_ctrl
   import ilha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic [LEN_W-1:0]  req_request_length,
   input  logic [ADDR_W-1:0] req_block_address,
   input  logic              req_last_block,
   output logic              rsp_strobe,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic [1:0]        rsp_status,
   output mem_req_type       mem_req,
   input  logic [HDR_W-1:0]  rd_data
);

   typedef enum logic [5:0] {
      S_INIT    = 6'b000001,
      S_IDLE    = 6'b000010,
      S_A_EVAL  = 6'b000100,
      S_A_SPLIT = 6'b001000,
      S_F_EVAL  = 6'b010000,
      S_F_MERGE = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [HDR_W-1:0]  need_ff, need_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [HDR_W-1:0]  sz_ff, sz_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              last_ff, last_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [HDR_W-1:0]  hdr_size;
   logic [HDR_W-1:0]  room;
   logic [HDR_W-1:0]  walk_next;
   logic [HDR_W-1:0]  len_round;
   logic [NEXT_W-1:0] free_next;
   logic [HDR_W-1:0]  merge_sum;
   logic              broken;
   logic              fits;

   // Header fields of the word just read, and the walk arithmetic.
   always_comb begin
      hdr_size  = {rd_data[HDR_W-1:1], 1'b0};
      room      = HDR_W'(HEAP_WORDS) - HDR_W'(pos_ff);
      broken    = (hdr_size == '0) || (hdr_size > room);
      fits      = !rd_data[0] && (hdr_size > HDR_W'(len_ff));
      walk_next = HDR_W'(pos_ff) + hdr_size;
      len_round = HDR_W'(req_request_length) + HDR_W'(1);
      free_next = NEXT_W'(addr_ff) + NEXT_W'(hdr_size);
      merge_sum = sz_ff + rd_data;
   end

   // Sequencer: walks headers for allocate, read-modify-write for free.
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      need_in       = need_ff;
      pos_in        = pos_ff;
      sz_in         = sz_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mem_req       = '0;

      case (state_ff)
         S_INIT: begin
            // Format the heap as one free block.
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = '0;
            mem_req.wr_data = HDR_RESET;
            state_in        = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               len_in  = req_request_length;
               need_in = {len_round[HDR_W-1:1], 1'b0};
               addr_in = req_block_address;
               last_in = req_last_block;
               if (req_command == CMD_FREE) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = req_block_address;
                  state_in        = S_F_EVAL;
               end else if (req_request_length == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ST_BADLEN;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  pos_in          = '0;
                  state_in        = S_A_EVAL;
               end
            end
         end
         S_A_EVAL: begin
            if (broken) begin
               rsp_strobe_in = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_NOFIT;
               state_in      = S_IDLE;
            end else if (fits) begin
               // Claim the block; split off the remainder in the next cycle.
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = need_ff | HDR_W'(1);
               sz_in           = hdr_size;
               if (need_ff < hdr_size) begin
                  state_in = S_A_SPLIT;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_addr_in   = pos_ff;
                  rsp_status_in = ST_OK;
                  state_in      = S_IDLE;
               end
            end else if (walk_next == HDR_W'(HEAP_WORDS)) begin
               rsp_strobe_in = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_NOFIT;
               state_in      = S_IDLE;
            end else begin
               // Step to the next header.
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = walk_next[ADDR_W-1:0];
               pos_in          = walk_next[ADDR_W-1:0];
            end
         end
         S_A_SPLIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff + need_ff[ADDR_W-1:0];
            mem_req.wr_data = sz_ff - need_ff;
            rsp_strobe_in   = 1'b1;
            rsp_addr_in     = pos_ff;
            rsp_status_in   = ST_OK;
            state_in        = S_IDLE;
         end
         S_F_EVAL: begin
            // Clear the allocated flag, then look at the following header.
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = addr_ff;
            mem_req.wr_data = hdr_size;
            sz_in           = hdr_size;
            if (!last_ff && (hdr_size != '0) && (free_next < NEXT_W'(HEAP_WORDS))) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = free_next[ADDR_W-1:0];
               state_in        = S_F_MERGE;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_addr_in   = addr_ff;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         S_F_MERGE: begin
            if (!rd_data[0]) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = addr_ff;
               mem_req.wr_data = {merge_sum[HDR_W-1:1], 1'b0};
            end
            rsp_strobe_in = 1'b1;
            rsp_addr_in   = addr_ff;
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      need_ff       <= need_in;
      pos_ff        <= pos_in;
      sz_ff         <= sz_in;
      addr_ff       <= addr_in;
      last_ff       <= last_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

@@ hw/rtl/implicit_list_heap_allocator.sv @@
`timescale 1ns / 1ps
// Implicit-list first-fit heap allocator over a 512-word header memory.
// Input channel: a word is taken at a rising edge with start high and busy
// low. req_command selects allocate (length in req_request_length) or free
// (req_block_address, with req_last_block suppressing the merge).
// Result channel: rsp_strobe is high for one cycle with rsp_result_address
// and rsp_status; the receiver takes it in that cycle and cannot stall it.
// An allocate with zero length answers in the cycle after acceptance.
// Any other allocate walks one header per cycle through the memory's single
// read port and answers when a fitting header is found, after splitting off
// any remainder; a miss answers after the last header. A free clears the
// allocated flag and reads the following header for a merge when one may
// apply. The next word can be accepted in the cycle the result is shown.
// Reset: busy stays high after reset while header zero is written as a
// single free block covering the whole heap.
module implicit_list_heap_allocator
   import ilha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic [LEN_W-1:0]  req_request_length,
   input  logic [ADDR_W-1:0] req_block_address,
   input  logic              req_last_block,
   output logic              rsp_strobe,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic [1:0]        rsp_status
);

`include "assert_macros.svh"

   mem_req_type      mem_req;
   logic [HDR_W-1:0] rd_data;

   // Sequencer.
   ilha_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_request_length (req_request_length),
      .req_block_address  (req_block_address),
      .req_last_block     (req_last_block),
      .rsp_strobe         (rsp_strobe),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .mem_req            (mem_req),
      .rd_data            (rd_data)
   );

   // Header memory.
   ilha_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // A read never targets the entry being written in the same cycle.
   `ASSERT_CLK(a_no_rw_clash, clock, reset, (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr), "read and write hit the same header")
   // An accepted word either answers at once or keeps the block busy.
   `ASSERT_CLK(a_accept_progress, clock, reset, (start && !busy) |=> (busy || rsp_strobe), "accepted word dropped")
   // A failed allocate reports address zero.
   `ASSERT_CLK(a_nofit_addr, clock, reset, (rsp_strobe && (rsp_status == ST_NOFIT || rsp_status == ST_BADLEN)) |-> (rsp_result_address == '0), "failed allocate with nonzero address")
   // The heap is formatted before any word is taken.
   `ASSERT_CLK(a_busy_after_reset, clock, reset, $fell(reset) |-> busy, "idle before heap formatted")

endmodule
